/* design/sspq_pkg.sv */
`timescale 1ns / 1ps

package sspq_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned TAG_BITS_DEF  = 16;
  localparam int unsigned PRIO_BITS_DEF = 16;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_TAG_W  = 16;
  localparam int unsigned OUT_PRIO_W = 16;
  localparam int unsigned OUT_CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_UPGRADE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_REMOVE,
    CELL_CLEAR,
    CELL_LOAD,
    CELL_SCAN
  } cell_act_e;

  typedef struct packed {
    cell_act_e act;
  } cell_ctrl_t;

endpackage

/* design/sspq_req_if.sv */
`timescale 1ns / 1ps

interface sspq_req_if
  import sspq_pkg::*;
#(
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [TAG_BITS-1:0]  entry_tag;
  logic [PRIO_BITS-1:0] entry_priority;

  modport source (output valid, op, entry_tag, entry_priority, input ready);
  modport sink   (input valid, op, entry_tag, entry_priority, output ready);
endinterface

/* design/sspq_rsp_if.sv */
`timescale 1ns / 1ps

interface sspq_rsp_if
  import sspq_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [OUT_TAG_W-1:0]  removed_tag;
  logic [OUT_TAG_W-1:0]  head_tag;
  logic [OUT_PRIO_W-1:0] head_priority;
  logic                  queue_empty;
  logic [OUT_CNT_W-1:0]  entry_count;

  modport source (output valid, status, removed_tag, head_tag, head_priority,
                  queue_empty, entry_count, input ready);
  modport sink   (input valid, status, removed_tag, head_tag, head_priority,
                  queue_empty, entry_count, output ready);
endinterface

/* design/stable_sorted_priority_queue.sv */
`timescale 1ns / 1ps
// Channel  Dir  Modport  Fields
// req_i    in   sink     op, entry_tag, entry_priority
// rsp_o    out  source   status, removed_tag, head_tag, head_priority,
//                        queue_empty, entry_count
//
// Insert, pop and clear: the request is taken in IDLE and its result goes through DONE into the
// output register, one request at a time. Upgrade: SCAN ripples the first-match flag one cell
// per cycle along the chain; CHECK takes the entry out (or gives NOTFOUND), INSERT puts it back.
// A new request is taken while a result still waits in the output register.
// Reset empties the queue at once; no clearing pass.

module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sspq_req_if.sink   req_i,
  sspq_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SCAN_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [SCAN_W-1:0]    scan_q, scan_d;
  logic [STATUS_W-1:0]  stat_q, stat_d;
  logic [TAG_BITS-1:0]  removed_q, removed_d;
  logic [TAG_BITS-1:0]  hold_tag_q, hold_tag_d;
  logic [PRIO_BITS-1:0] hold_prio_q, hold_prio_d;
  logic                 rsp_valid_q;
  logic                 rsp_load;
  cell_ctrl_t           ctrl;
  logic [TAG_BITS-1:0]  bc_tag;
  logic [PRIO_BITS-1:0] bc_prio;
  logic                 req_fire;

  logic [STATUS_W-1:0]   rsp_status_q;
  logic [OUT_TAG_W-1:0]  rsp_removed_q, rsp_head_tag_q;
  logic [OUT_PRIO_W-1:0] rsp_head_prio_q;
  logic                  rsp_empty_q;
  logic [OUT_CNT_W-1:0]  rsp_count_q;

  logic [TAG_BITS-1:0]  tag_w   [CAPACITY];
  logic [PRIO_BITS-1:0] prio_w  [CAPACITY];
  logic                 valid_w [CAPACITY];
  logic                 le_w    [CAPACITY];
  logic                 seen_w  [CAPACITY];

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign bc_tag      = (state_q == S_IDLE) ? req_i.entry_tag : hold_tag_q;
  assign bc_prio     = (state_q == S_IDLE) ? req_i.entry_priority : hold_prio_q;
  assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_le, prev_seen, prev_valid, next_valid;
    logic [TAG_BITS-1:0]  prev_tag, next_tag;
    logic [PRIO_BITS-1:0] prev_prio, next_prio;

    if (i == 0) begin : g_first
      assign prev_le    = 1'b1;
      assign prev_seen  = 1'b0;
      assign prev_tag   = '0;
      assign prev_prio  = '0;
      assign prev_valid = 1'b0;
    end else begin : g_mid
      assign prev_le    = le_w[i-1];
      assign prev_seen  = seen_w[i-1];
      assign prev_tag   = tag_w[i-1];
      assign prev_prio  = prio_w[i-1];
      assign prev_valid = valid_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_tag   = '0;
      assign next_prio  = '0;
      assign next_valid = 1'b0;
    end else begin : g_body
      assign next_tag   = tag_w[i+1];
      assign next_prio  = prio_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    sspq_cell #(
      .TAG_BITS  (TAG_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_tag_i    (bc_tag),
      .new_prio_i   (bc_prio),
      .prev_le_i    (prev_le),
      .prev_seen_i  (prev_seen),
      .prev_tag_i   (prev_tag),
      .prev_prio_i  (prev_prio),
      .prev_valid_i (prev_valid),
      .next_tag_i   (next_tag),
      .next_prio_i  (next_prio),
      .next_valid_i (next_valid),
      .tag_o        (tag_w[i]),
      .prio_o       (prio_w[i]),
      .valid_o      (valid_w[i]),
      .le_o         (le_w[i]),
      .seen_o       (seen_w[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    stat_d      = stat_q;
    removed_d   = removed_q;
    hold_tag_d  = hold_tag_q;
    hold_prio_d = hold_prio_q;
    ctrl.act    = CELL_HOLD;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          stat_d    = ST_OK;
          removed_d = '0;
          state_d   = S_DONE;
          case (req_i.op)
            OP_INSERT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                stat_d = ST_FULL;
              end else begin
                ctrl.act = CELL_INSERT;
                count_d  = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                stat_d = ST_EMPTY;
              end else begin
                removed_d = tag_w[0];
                ctrl.act  = CELL_POP;
                count_d   = count_q - 1'b1;
              end
            end
            OP_UPGRADE: begin
              ctrl.act    = CELL_LOAD;
              hold_tag_d  = req_i.entry_tag;
              hold_prio_d = req_i.entry_priority;
              scan_d      = '0;
              state_d     = S_SCAN;
            end
            OP_CLEAR: begin
              ctrl.act = CELL_CLEAR;
              count_d  = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        ctrl.act = CELL_SCAN;
        scan_d   = scan_q + 1'b1;
        if (scan_q == SCAN_W'(CAPACITY - 2)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (seen_w[CAPACITY-1]) begin
          ctrl.act = CELL_REMOVE;
          count_d  = count_q - 1'b1;
          state_d  = S_INSERT;
        end else begin
          stat_d  = ST_NOTFOUND;
          state_d = S_DONE;
        end
      end
      S_INSERT: begin
        ctrl.act = CELL_INSERT;
        count_d  = count_q + 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q      <= stat_d;
    removed_q   <= removed_d;
    hold_tag_q  <= hold_tag_d;
    hold_prio_q <= hold_prio_d;
    if (rsp_load) begin
      rsp_status_q    <= stat_q;
      rsp_removed_q   <= OUT_TAG_W'(removed_q);
      rsp_head_tag_q  <= valid_w[0] ? OUT_TAG_W'(tag_w[0]) : '0;
      rsp_head_prio_q <= valid_w[0] ? OUT_PRIO_W'(prio_w[0]) : '0;
      rsp_empty_q     <= (count_q == '0);
      rsp_count_q     <= OUT_CNT_W'(count_q);
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.removed_tag   = rsp_removed_q;
  assign rsp_o.head_tag      = rsp_head_tag_q;
  assign rsp_o.head_priority = rsp_head_prio_q;
  assign rsp_o.queue_empty   = rsp_empty_q;
  assign rsp_o.entry_count   = rsp_count_q;

endmodule

/* design/sspq_cell.sv */
`timescale 1ns / 1ps

module sspq_cell
  import sspq_pkg::*;
#(
  parameter int unsigned TAG_BITS  = TAG_BITS_DEF,
  parameter int unsigned PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [TAG_BITS-1:0]  new_tag_i,
  input  logic [PRIO_BITS-1:0] new_prio_i,
  input  logic                 prev_le_i,
  input  logic                 prev_seen_i,
  input  logic [TAG_BITS-1:0]  prev_tag_i,
  input  logic [PRIO_BITS-1:0] prev_prio_i,
  input  logic                 prev_valid_i,
  input  logic [TAG_BITS-1:0]  next_tag_i,
  input  logic [PRIO_BITS-1:0] next_prio_i,
  input  logic                 next_valid_i,
  output logic [TAG_BITS-1:0]  tag_o,
  output logic [PRIO_BITS-1:0] prio_o,
  output logic                 valid_o,
  output logic                 le_o,
  output logic                 seen_o
);

  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;
  logic                 valid_q, valid_d;
  logic                 seen_q, seen_d;
  logic                 le, match;

  assign le    = valid_q && (prio_q <= new_prio_i);
  assign match = valid_q && (tag_q == new_tag_i);

  always_comb begin
    tag_d   = tag_q;
    prio_d  = prio_q;
    valid_d = valid_q;
    seen_d  = seen_q;
    case (ctrl_i.act)
      CELL_INSERT: begin
        if (!le) begin
          if (prev_le_i) begin
            tag_d   = new_tag_i;
            prio_d  = new_prio_i;
            valid_d = 1'b1;
          end else begin
            tag_d   = prev_tag_i;
            prio_d  = prev_prio_i;
            valid_d = prev_valid_i;
          end
        end
      end
      CELL_POP: begin
        tag_d   = next_tag_i;
        prio_d  = next_prio_i;
        valid_d = next_valid_i;
      end
      CELL_REMOVE: begin
        if (seen_q) begin
          tag_d   = next_tag_i;
          prio_d  = next_prio_i;
          valid_d = next_valid_i;
        end
      end
      CELL_CLEAR: valid_d = 1'b0;
      CELL_LOAD:  seen_d  = match;
      CELL_SCAN:  seen_d  = seen_q | prev_seen_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    prio_q <= prio_d;
  end

  assign tag_o   = tag_q;
  assign prio_o  = prio_q;
  assign valid_o = valid_q;
  assign le_o    = le;
  assign seen_o  = seen_q;

endmodule
